FILE: sv/sops_pkg.sv
// Shared types, opcodes and helpers for the segmented odd prime sieve.
`timescale 1ns / 1ps
package sops_pkg;

  typedef enum logic [2:0] {
    KIND_STRIKE = 3'd0,
    KIND_SELF   = 3'd1,
    KIND_NEXT   = 3'd2,
    KIND_REWIND = 3'd3,
    KIND_FILL   = 3'd4,
    KIND_LOAD   = 3'd5,
    KIND_READ   = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_STRIKE,
    OP_SELF,
    OP_NEXT,
    OP_REWIND,
    OP_FILL,
    OP_LOAD,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [47:0] prime;
    logic [11:0] byte_index;
    logic [7:0]  byte_value;
  } entry_t;

  typedef struct packed {
    logic [47:0] number_out;
    logic        found;
    logic [7:0]  byte_out;
  } result_t;

  typedef struct packed {
    logic accepting;
  } back_stat_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_STR_M,
    S_STR_A,
    S_STR_K,
    S_WALK_RD,
    S_WALK_WR,
    S_SELF_RD,
    S_SELF_CHK,
    S_SELF_K,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FILL,
    S_READ_WAIT,
    S_EMIT
  } state_t;

  localparam logic [2:0] CFG_SEGMENT_INDEX = 3'd0;

  function automatic logic [2:0] low_bit(input logic [7:0] v);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) idx = 3'(i);
    end
    return idx;
  endfunction

endpackage

FILE: sv/sops_item_if.sv
// Input item channel: valid, ready and the item fields.
`timescale 1ns / 1ps
interface sops_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [47:0] prime;
  logic [11:0] byte_index;
  logic [7:0]  byte_value;

  modport source(output valid, kind, prime, byte_index, byte_value, input ready);
  modport sink(input valid, kind, prime, byte_index, byte_value, output ready);
endinterface

FILE: sv/sops_result_if.sv
// Result channel: valid, ready and the result fields.
`timescale 1ns / 1ps
interface sops_result_if;
  logic        valid;
  logic        ready;
  logic [47:0] number_out;
  logic        found;
  logic [7:0]  byte_out;

  modport source(output valid, number_out, found, byte_out, input ready);
  modport sink(input valid, number_out, found, byte_out, output ready);
endinterface

FILE: sv/segmented_odd_prime_sieve_unit.sv
// Top level of the segmented odd prime sieve: APB register, front end and engine.
//
//   channel   dir   handshake         payload
//   items     in    valid / ready     kind, prime, byte_index, byte_value
//   results   out   valid / ready     number_out, found, byte_out
//   apb       in    psel / penable    segment_index at byte address 0
//
// One item at a time through the bitmap RAM engine (one read port, one write port).
// Strike: a bit-serial remainder, setup states M, A and K, then a read and a
// write per struck bit. Self sieve: a read and a check of each bitmap bit, plus
// a strike walk per survivor. Next survivor: a read and a check per byte scanned;
// fill writes every byte. After reset, clearing the bitmap holds items off.
// The two-entry queue and the result register let each side stall on its own.
`timescale 1ns / 1ps
module segmented_odd_prime_sieve_unit #(
  parameter int SEGMENT_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  sops_item_if.sink     items,
  sops_result_if.source results
);
  localparam logic [63:0] SEG_STRIDE = 64'(SEGMENT_BYTES) * 64'd16;

  logic [31:0]          segment_index;
  logic [63:0]          first;
  logic                 q_valid;
  logic                 q_ready;
  sops_pkg::entry_t     q_entry;
  sops_pkg::back_stat_t stat;

  assign pready = 1'b1;
  assign prdata = (paddr == sops_pkg::CFG_SEGMENT_INDEX) ? segment_index : 32'd0;

  always_ff @(posedge clk) begin
    first <= 64'd3 + 64'(segment_index) * SEG_STRIDE;
    if (rst) begin
      segment_index <= '0;
    end else if (psel && penable && pwrite && pready
                 && paddr == sops_pkg::CFG_SEGMENT_INDEX) begin
      segment_index <= pwdata;
    end
  end

  sops_front #(.SEGMENT_BYTES(SEGMENT_BYTES)) u_front (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .stat   (stat),
    .q_valid(q_valid),
    .q_ready(q_ready),
    .q_entry(q_entry)
  );

  sops_back #(.SEGMENT_BYTES(SEGMENT_BYTES)) u_back (
    .clk    (clk),
    .rst    (rst),
    .first  (first),
    .q_valid(q_valid),
    .q_ready(q_ready),
    .q_entry(q_entry),
    .stat   (stat),
    .results(results)
  );
endmodule

FILE: sv/sops_ram.sv
// Generic single write port, single read port RAM with registered read.
`timescale 1ns / 1ps
module sops_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: sv/sops_front.sv
// Front end: accepts items, classifies them and queues them for the engine.
`timescale 1ns / 1ps
module sops_front #(
  parameter int SEGMENT_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst,
  sops_item_if.sink           items,
  input  sops_pkg::back_stat_t stat,
  output logic                q_valid,
  input  logic                q_ready,
  output sops_pkg::entry_t    q_entry
);
  sops_pkg::entry_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  sops_pkg::entry_t cls;
  logic             push;
  logic             pop;
  logic [31:0]      bi32;

  assign bi32 = 32'(items.byte_index);

  always_comb begin
    cls.prime      = items.prime;
    cls.byte_index = items.byte_index;
    cls.byte_value = items.byte_value;
    case (items.kind)
      sops_pkg::KIND_STRIKE:
        cls.op = (items.prime >= 48'd3 && items.prime[0]) ? sops_pkg::OP_STRIKE
                                                          : sops_pkg::OP_NOP;
      sops_pkg::KIND_SELF:   cls.op = sops_pkg::OP_SELF;
      sops_pkg::KIND_NEXT:   cls.op = sops_pkg::OP_NEXT;
      sops_pkg::KIND_REWIND: cls.op = sops_pkg::OP_REWIND;
      sops_pkg::KIND_FILL:   cls.op = sops_pkg::OP_FILL;
      sops_pkg::KIND_LOAD:
        cls.op = (bi32 < SEGMENT_BYTES) ? sops_pkg::OP_LOAD : sops_pkg::OP_NOP;
      sops_pkg::KIND_READ:
        cls.op = (bi32 < SEGMENT_BYTES) ? sops_pkg::OP_READ : sops_pkg::OP_NOP;
      default:               cls.op = sops_pkg::OP_NOP;
    endcase
  end

  assign items.ready = (count != 2'd2) && stat.accepting;
  assign push        = items.valid && items.ready;
  assign q_valid     = (count != 2'd0);
  assign q_entry     = slots[rd_ptr];
  assign pop         = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= cls;
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule

FILE: sv/sops_back.sv
// Back end: sieve engine over the bitmap RAM, with the result register.
`timescale 1ns / 1ps
module sops_back #(
  parameter int SEGMENT_BYTES = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [63:0]          first,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  sops_pkg::entry_t     q_entry,
  output sops_pkg::back_stat_t stat,
  sops_result_if.source        results
);
  localparam int SEG_BITS = SEGMENT_BYTES * 8;
  localparam int CW = $clog2(SEG_BITS + 1);
  localparam int AW = (SEGMENT_BYTES > 1) ? $clog2(SEGMENT_BYTES) : 1;
  localparam int RD = (SEGMENT_BYTES > 1) ? SEGMENT_BYTES : 2;
  localparam logic [63:0] SEG_BITS_W = 64'(SEG_BITS);
  localparam logic [CW-1:0] SEG_BITS_C = CW'(SEG_BITS);
  localparam logic [AW-1:0] LAST_BYTE = AW'(SEGMENT_BYTES - 1);

  sops_pkg::state_t  state;
  sops_pkg::state_t  state_next;
  sops_pkg::result_t res;
  sops_pkg::result_t out_res;
  logic              out_valid;
  logic [63:0]       p;
  logic [63:0]       k;
  logic [63:0]       m;
  logic [63:0]       dvd;
  logic [47:0]       rem;
  logic [5:0]        div_cnt;
  logic [CW-1:0]     j;
  logic [CW-1:0]     cursor;
  logic [AW-1:0]     fill_cnt;
  logic              self_mode;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [7:0]        wdata;
  logic [AW-1:0]     raddr;
  logic [7:0]        rdata;
  logic [48:0]       div_tmp;
  logic [7:0]        scan_mask;
  logic [CW-1:0]     scan_k;
  logic              emit_go;

  assign div_tmp   = {rem, dvd[63]};
  assign scan_mask = rdata & (8'hFF << cursor[2:0]);
  assign scan_k    = {cursor[CW-1:3], sops_pkg::low_bit(scan_mask)};
  assign emit_go   = !out_valid || results.ready;

  sops_ram #(.WIDTH(8), .DEPTH(RD)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= sops_pkg::S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    we         = 1'b0;
    waddr      = k[AW+2:3];
    wdata      = rdata & ~(8'h01 << k[2:0]);
    raddr      = k[AW+2:3];
    q_ready    = 1'b0;
    case (state)
      sops_pkg::S_CLEAR, sops_pkg::S_FILL: begin
        we    = 1'b1;
        waddr = fill_cnt;
        wdata = 8'hFF;
        if (fill_cnt == LAST_BYTE) begin
          state_next = (state == sops_pkg::S_CLEAR) ? sops_pkg::S_IDLE : sops_pkg::S_EMIT;
        end
      end
      sops_pkg::S_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          case (q_entry.op)
            sops_pkg::OP_STRIKE: state_next = sops_pkg::S_DIV;
            sops_pkg::OP_SELF:   state_next = sops_pkg::S_SELF_RD;
            sops_pkg::OP_NEXT:   state_next = sops_pkg::S_SCAN_RD;
            sops_pkg::OP_FILL:   state_next = sops_pkg::S_FILL;
            sops_pkg::OP_READ:   state_next = sops_pkg::S_READ_WAIT;
            default:             state_next = sops_pkg::S_EMIT;
          endcase
          if (q_entry.op == sops_pkg::OP_LOAD) begin
            we    = 1'b1;
            waddr = AW'(32'(q_entry.byte_index));
            wdata = q_entry.byte_value;
          end
          raddr = AW'(32'(q_entry.byte_index));
        end
      end
      sops_pkg::S_DIV: begin
        if (div_cnt == 6'd63) state_next = sops_pkg::S_STR_M;
      end
      sops_pkg::S_STR_M: state_next = sops_pkg::S_STR_A;
      sops_pkg::S_STR_A: state_next = sops_pkg::S_STR_K;
      sops_pkg::S_STR_K: state_next = sops_pkg::S_WALK_RD;
      sops_pkg::S_WALK_RD: begin
        if (k >= SEG_BITS_W) begin
          state_next = self_mode ? sops_pkg::S_SELF_RD : sops_pkg::S_EMIT;
        end else begin
          state_next = sops_pkg::S_WALK_WR;
        end
      end
      sops_pkg::S_WALK_WR: begin
        we         = 1'b1;
        state_next = sops_pkg::S_WALK_RD;
      end
      sops_pkg::S_SELF_RD: begin
        raddr      = j[AW+2:3];
        state_next = (j >= SEG_BITS_C) ? sops_pkg::S_EMIT : sops_pkg::S_SELF_CHK;
      end
      sops_pkg::S_SELF_CHK: begin
        state_next = rdata[j[2:0]] ? sops_pkg::S_SELF_K : sops_pkg::S_SELF_RD;
      end
      sops_pkg::S_SELF_K: state_next = sops_pkg::S_WALK_RD;
      sops_pkg::S_SCAN_RD: begin
        raddr      = cursor[AW+2:3];
        state_next = (cursor >= SEG_BITS_C) ? sops_pkg::S_EMIT : sops_pkg::S_SCAN_CHK;
      end
      sops_pkg::S_SCAN_CHK: begin
        state_next = (scan_mask != 8'h00) ? sops_pkg::S_EMIT : sops_pkg::S_SCAN_RD;
      end
      sops_pkg::S_READ_WAIT: state_next = sops_pkg::S_EMIT;
      sops_pkg::S_EMIT: begin
        if (emit_go) state_next = sops_pkg::S_IDLE;
      end
      default: state_next = sops_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state)
      sops_pkg::S_IDLE: begin
        res       <= '0;
        p         <= 64'(q_entry.prime);
        dvd       <= first;
        rem       <= '0;
        div_cnt   <= '0;
        j         <= '0;
        self_mode <= (q_entry.op == sops_pkg::OP_SELF);
      end
      sops_pkg::S_DIV: begin
        if (div_tmp >= {1'b0, p[47:0]}) rem <= 48'(div_tmp - {1'b0, p[47:0]});
        else                            rem <= div_tmp[47:0];
        dvd     <= {dvd[62:0], 1'b0};
        div_cnt <= div_cnt + 6'd1;
      end
      sops_pkg::S_STR_M: begin
        m <= (rem == 48'd0) ? first : first + (p - 64'(rem));
      end
      sops_pkg::S_STR_A: begin
        if (m == p)       m <= {p[62:0], 1'b0} + p;
        else if (!m[0])   m <= m + p;
      end
      sops_pkg::S_STR_K: k <= (m - first) >> 1;
      sops_pkg::S_WALK_RD: begin
        if (k >= SEG_BITS_W && self_mode) j <= j + CW'(1);
      end
      sops_pkg::S_WALK_WR: k <= k + p;
      sops_pkg::S_SELF_CHK: begin
        p <= first + {63'(j), 1'b0};
        if (!rdata[j[2:0]]) j <= j + CW'(1);
      end
      sops_pkg::S_SELF_K: k <= 64'(j) + p;
      sops_pkg::S_SCAN_RD: begin
        if (cursor >= SEG_BITS_C) cursor <= SEG_BITS_C;
      end
      sops_pkg::S_SCAN_CHK: begin
        if (scan_mask != 8'h00) begin
          res.number_out <= 48'(first + {63'(scan_k), 1'b0});
          res.found      <= 1'b1;
          cursor         <= scan_k + CW'(1);
        end else begin
          cursor <= {cursor[CW-1:3] + (CW-3)'(1), 3'b000};
        end
      end
      sops_pkg::S_READ_WAIT: res.byte_out <= rdata;
      default: ;
    endcase
    if (state == sops_pkg::S_EMIT && emit_go) out_res <= res;
    if (rst) begin
      cursor    <= '0;
      fill_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == sops_pkg::S_IDLE && q_valid && q_entry.op == sops_pkg::OP_REWIND) begin
        cursor <= '0;
      end
      if (state == sops_pkg::S_CLEAR || state == sops_pkg::S_FILL) begin
        fill_cnt <= (fill_cnt == LAST_BYTE) ? '0 : fill_cnt + AW'(1);
      end
      if (state == sops_pkg::S_EMIT && emit_go) out_valid <= 1'b1;
      else if (results.ready)                   out_valid <= 1'b0;
    end
  end

  assign stat.accepting     = (state != sops_pkg::S_CLEAR);
  assign results.valid      = out_valid;
  assign results.number_out = out_res.number_out;
  assign results.found      = out_res.found;
  assign results.byte_out   = out_res.byte_out;
endmodule

FILE: sv/sops_chk.sv
// Port-level checks on the sieve unit, bound to the top level.
`timescale 1ns / 1ps
module sops_chk (
  input logic        clk,
  input logic        rst,
  input logic        pready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [47:0] res_number,
  input logic        res_found,
  input logic [7:0]  res_byte
);
  a_no_beat_after_reset: assert property (@(posedge clk) $past(rst) |-> !res_valid)
    else $error("result beat right after reset");
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_number))
    else $error("stalled result dropped or changed");
  a_survivor_odd: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_found |-> res_number[0] && res_byte == 8'd0)
    else $error("survivor even or byte set");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_found |-> res_number == 48'd0)
    else $error("number without survivor");
  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");
endmodule

bind segmented_odd_prime_sieve_unit sops_chk u_sops_chk (
  .clk       (clk),
  .rst       (rst),
  .pready    (pready),
  .res_valid (results.valid),
  .res_ready (results.ready),
  .res_number(results.number_out),
  .res_found (results.found),
  .res_byte  (results.byte_out)
);
